// ===== src/tll_pkg.sv =====
// Shared types, codes and character tables for the tiny language lexer
`timescale 1ns / 1ps
package tll_pkg;

  // default saturation limit for token lengths
  localparam int unsigned LENGTH_LIMIT_DEFAULT = 255;

  // depth of the queue between scanner and emitter
  localparam int unsigned QUEUE_DEPTH = 4;

  // letters of a word kept for reserved word matching
  localparam int unsigned PREFIX_DEPTH = 6;
  localparam int unsigned RESERVED_COUNT = 8;

  // token kinds
  localparam logic [4:0] KIND_NUMBER = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_WORD0  = 5'd2;
  localparam logic [4:0] KIND_ASSIGN = 5'd10;
  localparam logic [4:0] KIND_PLUS   = 5'd11;
  localparam logic [4:0] KIND_MINUS  = 5'd12;
  localparam logic [4:0] KIND_TIMES  = 5'd13;
  localparam logic [4:0] KIND_OVER   = 5'd14;
  localparam logic [4:0] KIND_EQUAL  = 5'd15;
  localparam logic [4:0] KIND_LESS   = 5'd16;
  localparam logic [4:0] KIND_LPAREN = 5'd17;
  localparam logic [4:0] KIND_RPAREN = 5'd18;
  localparam logic [4:0] KIND_SEMI   = 5'd19;
  localparam logic [4:0] KIND_ERROR  = 5'd20;

  // character codes with a meaning of their own
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;

  // scanner states
  typedef enum logic [2:0] {
    ST_START,
    ST_NUMBER,
    ST_WORD,
    ST_ASSIGN,
    ST_COMMENT,
    ST_ERROR
  } scan_state_t;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] length;
  } token_t;

  // one queue entry: the results caused by one character
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } entry_t;

  // reserved words: if then else end repeat until read write
  localparam logic [7:0] RESERVED_TEXT [RESERVED_COUNT][PREFIX_DEPTH] = '{
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},
    '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h70, 8'h65, 8'h61, 8'h74},
    '{8'h75, 8'h6E, 8'h74, 8'h69, 8'h6C, 8'h00},
    '{8'h72, 8'h65, 8'h61, 8'h64, 8'h00, 8'h00},
    '{8'h77, 8'h72, 8'h69, 8'h74, 8'h65, 8'h00}
  };
  localparam logic [2:0] RESERVED_LEN [RESERVED_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NEWLINE) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  // special symbol decoder: hit flag and token kind
  function automatic logic [5:0] symbol_decode(input logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      8'h2B:   r = {1'b1, KIND_PLUS};
      8'h2D:   r = {1'b1, KIND_MINUS};
      8'h2A:   r = {1'b1, KIND_TIMES};
      8'h2F:   r = {1'b1, KIND_OVER};
      8'h3D:   r = {1'b1, KIND_EQUAL};
      8'h3C:   r = {1'b1, KIND_LESS};
      8'h28:   r = {1'b1, KIND_LPAREN};
      8'h29:   r = {1'b1, KIND_RPAREN};
      8'h3B:   r = {1'b1, KIND_SEMI};
      default: r = {1'b0, KIND_ERROR};
    endcase
    return r;
  endfunction

endpackage

// ===== src/tll_ifs.sv =====
// Valid/ready channel interfaces for characters and tokens
`timescale 1ns / 1ps
interface tll_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface tll_token_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic [7:0] token_length;
  logic       last_of_run;

  modport source (output valid, output token_kind, output token_length,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_length,
                input last_of_run, output ready);
endinterface

// ===== src/tll_front.sv =====
// Scanner front end: takes one character a cycle while push_ready is high, tracks the token state
`timescale 1ns / 1ps
module tll_front #(
  parameter int unsigned LENGTH_LIMIT = tll_pkg::LENGTH_LIMIT_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  tll_char_if.sink        char_in,
  output logic            push,
  output tll_pkg::entry_t push_data,
  input  logic            push_ready
);

  localparam int unsigned LW = $clog2(LENGTH_LIMIT + 1);

  tll_pkg::scan_state_t state, state_next;
  logic [LW-1:0] text_length, text_length_next;
  logic [7:0]    word_prefix [tll_pkg::PREFIX_DEPTH];

  logic          accept;
  logic [7:0]    c;
  logic          ws, digit, lower, sym_hit;
  logic [4:0]    sym_kind;
  logic [5:0]    sym_dec;
  logic [LW-1:0] grown;
  logic [16:0]   len_wide, grown_wide;
  logic [7:0]    len_out, grown_out;
  logic [4:0]    wkind;
  logic          emit;
  logic          prefix_we;
  logic [2:0]    prefix_idx;

  assign char_in.ready = push_ready;
  assign accept = char_in.valid && push_ready;
  assign c = char_in.character;

  // character classes
  assign ws       = tll_pkg::is_space(c);
  assign digit    = tll_pkg::is_digit(c);
  assign lower    = tll_pkg::is_lower(c);
  assign sym_dec  = tll_pkg::symbol_decode(c);
  assign sym_hit  = sym_dec[5];
  assign sym_kind = sym_dec[4:0];

  // saturating length and its 8-bit report value
  assign grown      = (text_length < LW'(LENGTH_LIMIT)) ? text_length + LW'(1) : text_length;
  assign len_wide   = 17'(text_length);
  assign grown_wide = 17'(grown);
  assign len_out    = (len_wide > 17'd255) ? 8'hFF : len_wide[7:0];
  assign grown_out  = (grown_wide > 17'd255) ? 8'hFF : grown_wide[7:0];

  // reserved word match over the stored prefix
  always_comb begin
    logic match;
    wkind = tll_pkg::KIND_IDENT;
    for (int k = tll_pkg::RESERVED_COUNT - 1; k >= 0; k--) begin
      match = (len_wide == 17'(tll_pkg::RESERVED_LEN[k]));
      for (int i = 0; i < tll_pkg::PREFIX_DEPTH; i++) begin
        if (3'(i) < tll_pkg::RESERVED_LEN[k] &&
            word_prefix[i] != tll_pkg::RESERVED_TEXT[k][i]) begin
          match = 1'b0;
        end
      end
      if (match) begin
        wkind = tll_pkg::KIND_WORD0 + 5'(k);
      end
    end
  end

  // next state and results of the current character
  always_comb begin
    state_next       = state;
    text_length_next = text_length;
    emit             = 1'b0;
    push_data        = '0;
    prefix_we        = 1'b0;
    prefix_idx       = text_length[2:0];
    unique case (state)
      tll_pkg::ST_NUMBER, tll_pkg::ST_WORD: begin
        if ((state == tll_pkg::ST_NUMBER) ? digit : lower) begin
          text_length_next = grown;
          prefix_we = (state == tll_pkg::ST_WORD) &&
                      (len_wide < 17'(tll_pkg::PREFIX_DEPTH));
        end else if (ws || sym_hit) begin
          emit = 1'b1;
          push_data.first.kind = (state == tll_pkg::ST_NUMBER) ?
                                 tll_pkg::KIND_NUMBER : wkind;
          push_data.first.length = len_out;
          push_data.second.kind = sym_kind;
          push_data.second.length = 8'd1;
          push_data.two = sym_hit;
          state_next = tll_pkg::ST_START;
        end else begin
          text_length_next = grown;
          state_next = tll_pkg::ST_ERROR;
        end
      end
      tll_pkg::ST_ASSIGN: begin
        text_length_next = grown;
        push_data.first.length = grown_out;
        if (c == tll_pkg::CH_EQUAL) begin
          emit = 1'b1;
          push_data.first.kind = tll_pkg::KIND_ASSIGN;
          state_next = tll_pkg::ST_START;
        end else if (ws) begin
          emit = 1'b1;
          push_data.first.kind = tll_pkg::KIND_ERROR;
          state_next = tll_pkg::ST_START;
        end else begin
          state_next = tll_pkg::ST_ERROR;
        end
      end
      tll_pkg::ST_COMMENT: begin
        if (c == tll_pkg::CH_RBRACE) begin
          state_next = tll_pkg::ST_START;
        end
      end
      tll_pkg::ST_ERROR: begin
        text_length_next = grown;
        if (ws) begin
          emit = 1'b1;
          push_data.first.kind = tll_pkg::KIND_ERROR;
          push_data.first.length = grown_out;
          state_next = tll_pkg::ST_START;
        end
      end
      default: begin
        state_next = tll_pkg::ST_START;
        text_length_next = '0;
        if (ws) begin
          state_next = tll_pkg::ST_START;
        end else if (c == tll_pkg::CH_LBRACE) begin
          state_next = tll_pkg::ST_COMMENT;
        end else if (digit) begin
          text_length_next = LW'(1);
          state_next = tll_pkg::ST_NUMBER;
        end else if (lower) begin
          text_length_next = LW'(1);
          prefix_we = 1'b1;
          prefix_idx = 3'd0;
          state_next = tll_pkg::ST_WORD;
        end else if (c == tll_pkg::CH_COLON) begin
          text_length_next = LW'(1);
          state_next = tll_pkg::ST_ASSIGN;
        end else if (sym_hit) begin
          emit = 1'b1;
          push_data.first.kind = sym_kind;
          push_data.first.length = 8'd1;
        end else begin
          text_length_next = LW'(1);
          state_next = tll_pkg::ST_ERROR;
        end
      end
    endcase
  end

  assign push = accept && emit;

  // scanner state and length counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tll_pkg::ST_START;
      text_length <= '0;
    end else if (accept) begin
      state <= state_next;
      text_length <= text_length_next;
    end
  end

  // first letters of the open word
  always_ff @(posedge clk) begin
    if (accept && prefix_we) begin
      word_prefix[prefix_idx] <= c;
    end
  end

endmodule

// ===== src/tll_queue.sv =====
// Short queue of result entries between scanner and emitter
`timescale 1ns / 1ps
module tll_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tll_pkg::entry_t push_data,
  output logic            push_ready,
  output logic            pop_valid,
  input  logic            pop,
  output tll_pkg::entry_t pop_data
);

  localparam int unsigned AW = $clog2(tll_pkg::QUEUE_DEPTH);

  tll_pkg::entry_t mem [tll_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_push, do_pop;

  assign push_ready = (count != (AW+1)'(tll_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/tll_back.sv =====
// Emitter: splits queue entries into single tokens on a registered output
`timescale 1ns / 1ps
module tll_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  input  tll_pkg::entry_t pop_data,
  output logic            pop,
  tll_token_if.source     tok_out
);

  logic phase;
  logic load;

  assign load = !tok_out.valid || tok_out.ready;
  assign pop  = load && pop_valid && (phase || !pop_data.two);

  // output register and second-token phase
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      tok_out.valid <= pop_valid;
      if (pop_valid) begin
        phase <= !phase && pop_data.two;
      end
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      if (phase) begin
        tok_out.token_kind <= pop_data.second.kind;
        tok_out.token_length <= pop_data.second.length;
        tok_out.last_of_run <= 1'b1;
      end else begin
        tok_out.token_kind <= pop_data.first.kind;
        tok_out.token_length <= pop_data.first.length;
        tok_out.last_of_run <= !pop_data.two;
      end
    end
  end

endmodule

// ===== src/tiny_language_lexer.sv =====
// Top level of the tiny language lexer
`timescale 1ns / 1ps
// Scans a stream of ASCII characters, one per transfer on char_in, and
// produces a transfer on tok_out for each finished token with its kind and
// length (saturating at LENGTH_LIMIT and at 255). The scanner takes one
// character every clock while the queue has room; a character that closes
// a number or word with a special symbol yields two tokens, which the
// output register sends one after the other. A four-entry queue between
// scanner and emitter lets the scanner keep taking characters while the
// sink stalls, and char_in stalls only when that queue is full. The first
// token of a character is written into the queue and then into the output
// register before it is presented on tok_out. No clearing pass follows
// reset, and a token still open when input stops is held, not sent.
module tiny_language_lexer #(
  parameter int unsigned LENGTH_LIMIT = tll_pkg::LENGTH_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  tll_char_if.sink    char_in,
  tll_token_if.source tok_out
);

  logic            push, push_ready, pop, pop_valid;
  tll_pkg::entry_t push_data, pop_data;

  // scanner
  tll_front #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .push      (push),
    .push_data (push_data),
    .push_ready(push_ready)
  );

  // decoupling queue
  tll_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data)
  );

  // emitter
  tll_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_data (pop_data),
    .pop      (pop),
    .tok_out  (tok_out)
  );

endmodule
